### hdl/utf8_sanitizer_stream_defines.svh
// ----------------------------------------------------------------------------
// utf8 sanitizer assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZER_STREAM_DEFINES_SVH
`define UTF8_SANITIZER_STREAM_DEFINES_SVH

`ifndef SYNTH
`define U8S_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define U8S_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define U8S_ASSERT(lbl, prop, msg)
`define U8S_NEVER(lbl, cond, msg)
`endif

`endif

### hdl/u8s_pkg.sv
// ----------------------------------------------------------------------------
// u8s_pkg
// byte class constants and escape character helpers for the utf8 sanitizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8s_pkg;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD_LO    = 8'hC0;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD_END   = 8'hF8;
    localparam logic [7:0] ASCII_END  = 8'h80;

    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_A       = 8'h41;

    localparam logic [2:0] REPL_LAST  = 3'd5;
    localparam logic [1:0] ESC_LAST   = 2'd3;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_CODE;
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return (b >= LEAD_LO) && (b < LEAD_END);
    endfunction

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        if (b < LEAD3_LO) begin
            len = 3'd2;
        end else if (b < LEAD4_LO) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CH_0 + {4'd0, nib};
        end else begin
            c = CH_A + {4'd0, nib - 4'd10};
        end
        return c;
    endfunction

    // \xHH, one character per index
    function automatic logic [7:0] esc_char(input logic [1:0] idx, input logic [7:0] b);
        logic [7:0] c;
        case (idx)
            2'd0: c = CH_BSLASH;
            2'd1: c = CH_X;
            2'd2: c = hex_char(b[7:4]);
            default: c = hex_char(b[3:0]);
        endcase
        return c;
    endfunction

    // \uFFFD, one character per index
    function automatic logic [7:0] repl_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = CH_BSLASH;
            3'd1: c = CH_U;
            3'd2: c = CH_F;
            3'd3: c = CH_F;
            3'd4: c = CH_F;
            default: c = CH_D;
        endcase
        return c;
    endfunction

endpackage

### hdl/utf8_sanitizer_stream.sv
// ----------------------------------------------------------------------------
// utf8_sanitizer_stream
// utf8 validation with escape replacement, at most one byte character out per cycle
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_ready carry i_in_byte and i_end_of_text
// output channel: o_out_valid / i_out_ready carry o_out_byte and o_run_last,
// o_run_last marks the final output byte caused by one input transfer
// one input transfer at a time: o_in_ready is high only while the sequencer
// is idle, then each output character passes through a single character
// select unit feeding the output register
// ascii or completed sequence: the transfer moves the sequencer to its start
// or copy state, which writes the first output byte to the output register
// a held continuation is stored at its transfer, a held lead in the start state,
// both with no output; \xHH and \uFFFD go out one character at a time, a
// completed sequence one byte at a time; worst case per input is 20 output
// bytes, with the start byte handled in its own state before the final \uFFFD
// when the receiver stalls the output register holds and the sequencer waits
// synchronous active-low reset empties the held sequence and the output
// register; the block is ready as soon as reset is released
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_sanitizer_stream_defines.svh"

module utf8_sanitizer_stream (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_CHEX  = 3'd2;
    localparam logic [2:0] ST_REPL  = 3'd3;
    localparam logic [2:0] ST_HEX   = 3'd4;
    localparam logic [2:0] ST_COPY  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic [2:0] r_need, n_need;
    logic [7:0] r_held [0:2];
    logic [7:0] n_held [0:2];
    logic [7:0] r_c, n_c;
    logic       r_eot, n_eot;
    logic       r_final, n_final;
    logic [2:0] r_idx, n_idx;
    logic [1:0] r_k, n_k;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;

    logic       w_slot;
    logic       w_emit;
    logic [7:0] w_ebyte;
    logic       w_elast;
    logic       w_flush_last;
    logic [7:0] w_held_k;
    logic [1:0] w_k_inc;

    assign w_slot       = !r_ovalid || i_out_ready;
    assign w_flush_last = r_final || (u8s_pkg::is_lead(r_c) && !r_eot);
    assign w_k_inc      = r_k + 2'd1;
    assign o_in_ready   = i_rst_n && (r_state == ST_IDLE);

    always_comb begin
        case (r_k)
            2'd0: w_held_k = r_held[0];
            2'd1: w_held_k = r_held[1];
            2'd2: w_held_k = r_held[2];
            default: w_held_k = r_c;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_need  = r_need;
        n_held  = r_held;
        n_c     = r_c;
        n_eot   = r_eot;
        n_final = r_final;
        n_idx   = r_idx;
        n_k     = r_k;
        w_emit  = 1'b0;
        w_ebyte = r_c;
        w_elast = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_c   = i_in_byte;
                    n_eot = i_end_of_text;
                    n_idx = 3'd0;
                    if (r_cnt == 2'd0) begin
                        n_state = ST_START;
                    end else if (u8s_pkg::is_cont(i_in_byte)) begin
                        if (({1'b0, r_cnt} + 3'd1) >= r_need) begin
                            n_state = ST_COPY;
                            n_k     = 2'd0;
                        end else begin
                            n_held[r_cnt] = i_in_byte;
                            n_cnt         = r_cnt + 2'd1;
                            if (i_end_of_text) begin
                                n_state = ST_REPL;
                                n_final = 1'b1;
                            end
                        end
                    end else begin
                        n_state = ST_REPL;
                        n_final = 1'b0;
                    end
                end
            end
            ST_START: begin
                if (r_c < u8s_pkg::ASCII_END) begin
                    w_emit  = 1'b1;
                    w_ebyte = r_c;
                    w_elast = 1'b1;
                    if (w_slot) begin
                        n_state = ST_IDLE;
                    end
                end else if (u8s_pkg::is_lead(r_c)) begin
                    n_held[0] = r_c;
                    n_cnt     = 2'd1;
                    n_need    = u8s_pkg::seq_len(r_c);
                    n_idx     = 3'd0;
                    n_final   = 1'b1;
                    n_state   = r_eot ? ST_REPL : ST_IDLE;
                end else begin
                    n_idx   = 3'd0;
                    n_state = ST_CHEX;
                end
            end
            ST_CHEX: begin
                w_emit  = 1'b1;
                w_ebyte = u8s_pkg::esc_char(r_idx[1:0], r_c);
                w_elast = (r_idx[1:0] == u8s_pkg::ESC_LAST);
                if (w_slot) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx[1:0] == u8s_pkg::ESC_LAST) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_REPL: begin
                w_emit  = 1'b1;
                w_ebyte = u8s_pkg::repl_char(r_idx);
                w_elast = (r_idx == u8s_pkg::REPL_LAST) && (r_cnt == 2'd1) && w_flush_last;
                if (w_slot) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == u8s_pkg::REPL_LAST) begin
                        n_idx = 3'd0;
                        if (r_cnt > 2'd1) begin
                            n_state = ST_HEX;
                            n_k     = 2'd1;
                        end else begin
                            n_cnt   = 2'd0;
                            n_need  = 3'd0;
                            n_state = r_final ? ST_IDLE : ST_START;
                        end
                    end
                end
            end
            ST_HEX: begin
                w_emit  = 1'b1;
                w_ebyte = u8s_pkg::esc_char(r_idx[1:0], w_held_k);
                w_elast = (r_idx[1:0] == u8s_pkg::ESC_LAST) && (w_k_inc == r_cnt)
                          && w_flush_last;
                if (w_slot) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx[1:0] == u8s_pkg::ESC_LAST) begin
                        n_idx = 3'd0;
                        if (w_k_inc < r_cnt) begin
                            n_k = w_k_inc;
                        end else begin
                            n_cnt   = 2'd0;
                            n_need  = 3'd0;
                            n_state = r_final ? ST_IDLE : ST_START;
                        end
                    end
                end
            end
            ST_COPY: begin
                w_emit  = 1'b1;
                w_ebyte = (r_k == r_cnt) ? r_c : w_held_k;
                w_elast = (r_k == r_cnt);
                if (w_slot) begin
                    if (r_k == r_cnt) begin
                        n_cnt   = 2'd0;
                        n_need  = 3'd0;
                        n_state = ST_IDLE;
                    end else begin
                        n_k = w_k_inc;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = 2'd0;
                n_need  = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= 2'd0;
            r_need   <= 3'd0;
            r_final  <= 1'b0;
            r_idx    <= 3'd0;
            r_k      <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_need  <= n_need;
            r_final <= n_final;
            r_idx   <= n_idx;
            r_k     <= n_k;
            if (w_emit && w_slot) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_c    <= n_c;
        r_eot  <= n_eot;
        if (w_emit && w_slot) begin
            r_obyte <= w_ebyte;
            r_olast <= w_elast;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_run_last  = r_olast;

    // held sequence shorter than its full length
    `U8S_ASSERT(a_held_short, (r_cnt != 2'd0) |-> ((r_need > {1'b0, r_cnt}) && (r_need <= 3'd4)), "held count not below needed length")
    // copy index never passes the held count
    `U8S_ASSERT(a_copy_idx, (r_state == ST_COPY) |-> (r_k <= r_cnt), "copy index past held count")
    // hex escapes of held bytes only cover continuations
    `U8S_ASSERT(a_hex_idx, (r_state == ST_HEX) |-> ((r_k != 2'd0) && (r_k < r_cnt)), "held escape index out of range")
    // nothing held while a start byte is processed
    `U8S_ASSERT(a_start_empty, ((r_state == ST_START) || (r_state == ST_CHEX)) |-> (r_cnt == 2'd0), "start byte with bytes held")

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for utf8_sanitizer_stream: a directed table of text bytes
// (typed-in results where obvious) followed by random text built mostly from
// well-formed utf8 sequences with broken ones and stray bytes mixed in; every
// output transfer is checked against typed-in text or a sanitizer model in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [7:0] b;
        logic       eot;
        bit         fixed;
        string      want;
    } t_text_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b1;
    logic [7:0] o_out_byte;
    logic       o_run_last;

    t_text_item text_items[$];
    t_text_item in_flight[$];
    t_out_char  expected_chars[$];
    logic [7:0] step_chars[$];

    logic [7:0] held_q [3];
    logic [1:0] held_n = 2'd0;
    logic [2:0] seq_need = 3'd0;

    string hex_digits = "0123456789ABCDEF";
    int    errors = 0;
    int    stall_left = 0;
    bit    quiet = 1'b0;

    utf8_sanitizer_stream dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    // sanitizer model
    function automatic void put_char(input logic [7:0] c);
        step_chars.insert(step_chars.size(), c);
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_char(s[i]);
        end
    endfunction

    function automatic void put_escape(input logic [7:0] b);
        put_str("\\x");
        put_char(hex_digits[b[7:4]]);
        put_char(hex_digits[b[3:0]]);
    endfunction

    function automatic void flush_held();
        put_str("\\uFFFD");
        for (int k = 1; k < int'(held_n); k++) begin
            put_escape(held_q[k]);
        end
        held_n = 2'd0;
        seq_need = 3'd0;
    endfunction

    function automatic void take_start(input logic [7:0] c);
        if (c < 8'h80) begin
            put_char(c);
        end else if (c >= 8'hC0 && c < 8'hF8) begin
            held_q[0] = c;
            held_n = 2'd1;
            seq_need = (c < 8'hE0) ? 3'd2 : (c < 8'hF0) ? 3'd3 : 3'd4;
        end else begin
            put_escape(c);
        end
    endfunction

    function automatic void sanitize_step(input logic [7:0] c, input logic eot);
        if (held_n == 2'd0) begin
            take_start(c);
        end else if (c[7:6] == 2'b10) begin
            if (int'(held_n) + 1 >= int'(seq_need)) begin
                for (int k = 0; k < int'(held_n); k++) begin
                    put_char(held_q[k]);
                end
                put_char(c);
                held_n = 2'd0;
                seq_need = 3'd0;
            end else begin
                held_q[held_n] = c;
                held_n = held_n + 2'd1;
            end
        end else begin
            flush_held();
            take_start(c);
        end
        if (eot && held_n != 2'd0) begin
            flush_held();
        end
    endfunction

    // stimulus building
    function automatic void add_row(input logic [7:0] b, input logic eot,
                                    input bit fixed, input string want);
        t_text_item item;
        item.b = b;
        item.eot = eot;
        item.fixed = fixed;
        item.want = want;
        text_items.insert(text_items.size(), item);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        add_row(b, ($urandom_range(0, 11) == 0), 1'b0, "");
    endfunction

    function automatic logic [7:0] rand_lead(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            2: return {3'b110, r[4:0]};
            3: return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    // receiver stalls
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // input transfers feed the model, output transfers are checked
    always @(posedge i_clk) begin
        t_text_item acc;
        t_out_char  exp_c;
        t_out_char  put_c;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                acc = in_flight.pop_front();
                step_chars = {};
                sanitize_step(i_in_byte, i_end_of_text);
                if (acc.fixed) begin
                    step_chars = {};
                    put_str(acc.want);
                end
                foreach (step_chars[k]) begin
                    put_c.ch   = step_chars[k];
                    put_c.last = (k == step_chars.size() - 1);
                    expected_chars.insert(expected_chars.size(), put_c);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: output with none expected, got byte %02h last %0b",
                             $time, o_out_byte, o_run_last);
                    errors++;
                end else begin
                    exp_c = expected_chars.pop_front();
                    if (o_out_byte !== exp_c.ch) begin
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, exp_c.ch, o_out_byte);
                        errors++;
                    end
                    if (o_run_last !== exp_c.last) begin
                        $display("%0t: run_last expected %0b got %0b",
                                 $time, exp_c.last, o_run_last);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        int n_dir;
        int pick;
        int len;
        int ncont;

        // byte, end of text, typed-in result, result text
        add_row(8'h41, 1'b0, 1'b1, "A");
        add_row(8'h00, 1'b0, 1'b0, "");
        add_row(8'h7F, 1'b0, 1'b0, "");
        add_row(8'h80, 1'b0, 1'b1, "\\x80");
        add_row(8'hBF, 1'b0, 1'b1, "\\xBF");
        add_row(8'hF8, 1'b0, 1'b1, "\\xF8");
        add_row(8'hFF, 1'b0, 1'b1, "\\xFF");
        add_row(8'hC2, 1'b0, 1'b1, "");
        add_row(8'hA9, 1'b0, 1'b0, "");
        add_row(8'hE2, 1'b0, 1'b1, "");
        add_row(8'h82, 1'b0, 1'b1, "");
        add_row(8'hAC, 1'b0, 1'b0, "");
        add_row(8'hF0, 1'b0, 1'b1, "");
        add_row(8'h9F, 1'b0, 1'b1, "");
        add_row(8'h98, 1'b0, 1'b1, "");
        add_row(8'h80, 1'b0, 1'b0, "");
        add_row(8'hC0, 1'b1, 1'b1, "\\uFFFD");
        add_row(8'hE0, 1'b0, 1'b1, "");
        add_row(8'h80, 1'b0, 1'b1, "");
        add_row(8'h41, 1'b0, 1'b1, "\\uFFFD\\x80A");
        add_row(8'hF7, 1'b0, 1'b1, "");
        add_row(8'h80, 1'b0, 1'b1, "");
        add_row(8'hBF, 1'b0, 1'b1, "");
        add_row(8'hE0, 1'b1, 1'b0, "");
        add_row(8'hDF, 1'b0, 1'b1, "");
        add_row(8'hFF, 1'b1, 1'b1, "\\uFFFD\\xFF");
        add_row(8'h41, 1'b1, 1'b1, "A");
        n_dir = text_items.size();

        // mostly well-formed text, some broken sequences and stray bytes
        while (text_items.size() < n_dir + 350) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                add_byte(8'($urandom_range(0, 127)));
            end else if (pick <= 7) begin
                len = $urandom_range(2, 4);
                add_byte(rand_lead(len));
                ncont = (pick == 7) ? $urandom_range(0, len - 2) : len - 1;
                repeat (ncont) add_byte({2'b10, 6'($urandom)});
                if (pick == 7) begin
                    add_byte(8'($urandom_range(0, 1) ? $urandom_range(0, 127)
                                                     : $urandom_range(192, 255)));
                end
            end else if (pick == 8) begin
                add_byte(8'($urandom_range(0, 1) ? $urandom_range(128, 191)
                                                 : $urandom_range(248, 255)));
            end else begin
                add_byte(8'($urandom));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < text_items.size(); n++) begin
            if (n >= text_items.size() - 60) begin
                quiet = 1'b1;
            end
            if (!quiet && (n % 64) < 48 && $urandom_range(0, 3) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            in_flight.insert(in_flight.size(), text_items[n]);
            i_in_valid <= 1'b1;
            i_in_byte <= text_items[n].b;
            i_end_of_text <= text_items[n].eot;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/u8s_pkg.sv
hdl/utf8_sanitizer_stream.sv
verif/tb.sv
